// ===== rtl/stq_pkg.sv =====
package stq_pkg;

   // request codes
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DONE    = 2'd0;
   localparam logic [1:0] KIND_FIRED   = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   // one queue entry: expiry time and the timer it belongs to
   typedef struct packed {
      logic [63:0] expiry;
      logic [3:0]  id;
   } stq_entry_type;

endpackage

// ===== rtl/stq_ram.sv =====
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/sorted_timer_expiry_queue_core.sv =====
// Sorted timer queue. Timers are kept in expiry order in a ring held in a
// single simple dual-port RAM (one write and one registered read a cycle),
// with the entry at the head mirrored in flops so the due check is
// immediate. A request is taken when start is high and busy is low; each
// result appears on the rsp_ ports for exactly one cycle with rsp_strobe
// high and must be taken then, the block never holds a result back.
// An accepted add to a non-empty ring, or a delete of an active timer,
// walks the ring one entry a cycle; every add or delete ends in a single
// result. A tick checks the head and then fires the due timers, results
// coming out back to back, one per cycle, from the RAM read of the next
// entry. Busy falls as soon as the last result is in the output register,
// so the next request can follow while that result is still on the ports.
module sorted_timer_expiry_queue_core #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_delay,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_fired_id,
   output logic        rsp_last,
   output logic        rsp_due_now,
   output logic [4:0]  rsp_queued_count
);

   import stq_pkg::*;

   localparam int IDW = $clog2(NUM_TIMERS);
   localparam int CW  = $clog2(NUM_TIMERS + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADD_RD    = 4'd1;
   localparam logic [3:0] S_ADD_WALK  = 4'd2;
   localparam logic [3:0] S_ADD_PLACE = 4'd3;
   localparam logic [3:0] S_DEL_RD    = 4'd4;
   localparam logic [3:0] S_DEL_WALK  = 4'd5;
   localparam logic [3:0] S_TICK_CHK  = 4'd6;
   localparam logic [3:0] S_TICK_POP  = 4'd7;
   localparam logic [3:0] S_RESP      = 4'd8;

   // ring pointer step with wrap
   function automatic logic [IDW-1:0] ptr_inc(input logic [IDW-1:0] p);
      return (p == IDW'(NUM_TIMERS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDW-1:0] ptr_dec(input logic [IDW-1:0] p);
      return (p == '0) ? IDW'(NUM_TIMERS - 1) : p - 1'b1;
   endfunction

   // control state
   logic [3:0]          state_ff, state_in;
   logic [63:0]         tick_ff, tick_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [IDW-1:0]      base_ff, base_in;
   logic [IDW-1:0]      rp_ff, rp_in;
   logic [IDW-1:0]      wp_ff, wp_in;
   logic                found_ff, found_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;

   // request payload held for the walk
   logic [63:0]         exp_ff, exp_in;
   logic [3:0]          id_ff, id_in;
   logic [1:0]          kind_ff, kind_in;
   stq_entry_type       head_ff, head_in;

   // output register
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [3:0]          rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_due_ff, rsp_due_in;
   logic [4:0]          rsp_count_ff, rsp_count_in;

   // ram port
   logic                wr_en;
   logic [IDW-1:0]      wr_addr;
   stq_entry_type       wr_data;
   logic [IDW-1:0]      rd_addr;
   logic [$bits(stq_entry_type)-1:0] rd_raw;
   stq_entry_type       rd_entry;

   // helpers
   logic                req_id_ok;
   logic [IDW-1:0]      req_idx;
   logic [IDW-1:0]      id_idx;
   logic [IDW-1:0]      head_idx;
   logic [IDW:0]        pos_sum;
   logic [IDW-1:0]      pos_len;
   logic [IDW-1:0]      tail;
   logic                head_due;
   logic [CW-1:0]       len_less;
   logic                next_due;
   stq_entry_type       new_entry;

   stq_ram #(
      .WIDTH ($bits(stq_entry_type)),
      .DEPTH (NUM_TIMERS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = stq_entry_type'(rd_raw);

   assign req_id_ok = (IDW+4)'(req_timer_id) < (IDW+4)'(NUM_TIMERS);
   assign req_idx   = IDW'(req_timer_id);
   assign id_idx    = IDW'(id_ff);
   assign head_idx  = IDW'(head_ff.id);

   // physical slot of logical position len, and of the tail entry
   assign pos_sum = {1'b0, base_ff} + (IDW+1)'(len_ff);
   assign pos_len = (pos_sum >= (IDW+1)'(NUM_TIMERS)) ?
                    IDW'(pos_sum - (IDW+1)'(NUM_TIMERS)) : IDW'(pos_sum);
   assign tail    = ptr_dec(pos_len);

   assign head_due  = (len_ff != '0) && (head_ff.expiry <= tick_ff);
   assign len_less  = len_ff - 1'b1;
   // due check on the entry behind the head, once the head is gone
   assign next_due  = (len_less != '0) && (rd_entry.expiry <= tick_ff);
   assign new_entry = '{expiry: exp_ff, id: id_ff};

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      found_in      = found_ff;
      active_in     = active_ff;
      exp_in        = exp_ff;
      id_in         = id_ff;
      kind_in       = kind_ff;
      head_in       = head_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_due_in    = rsp_due_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = wp_ff;
      wr_data       = rd_entry;
      rd_addr       = rp_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in   = req_timer_id;
               exp_in  = tick_ff + 64'(req_delay);
               kind_in = KIND_DONE;
               case (req_type)
                  REQ_ADD: begin
                     if (!req_id_ok || active_ff[req_idx] ||
                         len_ff >= CW'(NUM_TIMERS)) begin
                        kind_in  = KIND_REFUSED;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
                  REQ_DELETE: begin
                     if (!req_id_ok) begin
                        kind_in  = KIND_REFUSED;
                        state_in = S_RESP;
                     end else if (active_ff[req_idx]) begin
                        state_in = S_DEL_RD;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  REQ_TICK: begin
                     tick_in  = tick_ff + 64'd1;
                     state_in = S_TICK_CHK;
                  end
                  default: begin
                     kind_in  = KIND_REFUSED;
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // add: walk back from the tail, moving later-or-equal entries up one
         S_ADD_RD: begin
            if (len_ff == '0) begin
               wr_en     = 1'b1;
               wr_addr   = base_ff;
               wr_data   = new_entry;
               active_in[id_idx] = 1'b1;
               len_in    = len_ff + 1'b1;
               state_in  = S_RESP;
            end else begin
               rd_addr  = tail;
               rp_in    = tail;
               wp_in    = pos_len;
               cnt_in   = len_ff;
               state_in = S_ADD_WALK;
            end
         end

         S_ADD_WALK: begin
            wr_en   = 1'b1;
            wr_addr = wp_ff;
            if (rd_entry.expiry >= exp_ff) begin
               wr_data = rd_entry;
               if (cnt_ff == CW'(1)) begin
                  wp_in    = rp_ff;
                  state_in = S_ADD_PLACE;
               end else begin
                  rd_addr = ptr_dec(rp_ff);
                  wp_in   = rp_ff;
                  rp_in   = ptr_dec(rp_ff);
                  cnt_in  = cnt_ff - 1'b1;
               end
            end else begin
               wr_data  = new_entry;
               active_in[id_idx] = 1'b1;
               len_in   = len_ff + 1'b1;
               state_in = S_RESP;
            end
         end

         // new timer goes in at the head
         S_ADD_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = wp_ff;
            wr_data  = new_entry;
            active_in[id_idx] = 1'b1;
            len_in   = len_ff + 1'b1;
            state_in = S_RESP;
         end

         // delete: walk forward, close the gap behind the match
         S_DEL_RD: begin
            rd_addr  = base_ff;
            rp_in    = base_ff;
            cnt_in   = len_ff;
            found_in = 1'b0;
            state_in = S_DEL_WALK;
         end

         S_DEL_WALK: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = wp_ff;
               wr_data = rd_entry;
            end else if (rd_entry.id == id_ff) begin
               found_in = 1'b1;
            end
            if (cnt_ff == CW'(1)) begin
               len_in   = len_less;
               active_in[id_idx] = 1'b0;
               state_in = S_RESP;
            end else begin
               rd_addr = ptr_inc(rp_ff);
               wp_in   = rp_ff;
               rp_in   = ptr_inc(rp_ff);
               cnt_in  = cnt_ff - 1'b1;
            end
         end

         S_TICK_CHK: begin
            if (head_due) begin
               rd_addr  = ptr_inc(base_ff);
               state_in = S_TICK_POP;
            end else begin
               kind_in  = KIND_DONE;
               id_in    = 4'd0;
               state_in = S_RESP;
            end
         end

         // fire the head; the entry behind it has just been read
         S_TICK_POP: begin
            base_in   = ptr_inc(base_ff);
            head_in   = rd_entry;
            len_in    = len_less;
            active_in[head_idx] = 1'b0;
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_FIRED;
            rsp_id_in     = head_ff.id;
            rsp_last_in   = !next_due;
            rsp_due_in    = next_due;
            rsp_count_in  = 5'(len_less);
            if (next_due) begin
               rd_addr = ptr_inc(ptr_inc(base_ff));
            end else begin
               state_in = S_IDLE;
            end
         end

         S_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = kind_ff;
            rsp_id_in     = id_ff;
            rsp_last_in   = 1'b1;
            rsp_due_in    = head_due;
            rsp_count_in  = 5'(len_ff);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // head copy follows every write to the head slot
      if (wr_en && (wr_addr == base_ff)) begin
         head_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= '0;
         len_ff        <= '0;
         cnt_ff        <= '0;
         base_ff       <= '0;
         rp_ff         <= '0;
         wp_ff         <= '0;
         found_ff      <= 1'b0;
         active_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         len_ff        <= len_in;
         cnt_ff        <= cnt_in;
         base_ff       <= base_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         found_ff      <= found_in;
         active_ff     <= active_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff       <= exp_in;
      id_ff        <= id_in;
      kind_ff      <= kind_in;
      head_ff      <= head_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_due_ff   <= rsp_due_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fired_id     = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_due_now      = rsp_due_ff;
   assign rsp_queued_count = rsp_count_ff;

endmodule

// ===== tb/sv/sorted_timer_expiry_queue_core_test.sv =====
module sorted_timer_expiry_queue_core_test;
   import stq_pkg::*;

   // a request code the block does not know, refused with no change
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int TIMER_SLOTS = 16;
   // slowest run is far below this: ~260 requests, each at most a ring walk,
   // up to sixteen fired results and an optional idle gap from the sender
   localparam int CYCLE_LIMIT = 200000;
   // drain time after the last result, above the longest ring walk
   localparam int DRAIN_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [3:0]  req_timer_id;
   logic [31:0] req_delay;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_fired_id;
   logic        rsp_last;
   logic        rsp_due_now;
   logic [4:0]  rsp_queued_count;

   // one result as the block should show it
   typedef struct {
      logic [1:0] kind;
      logic [3:0] id;
      logic       last;
      logic       due;
      logic [4:0] count;
   } expiry_result_type;

   // results still owed by the block, oldest first
   expiry_result_type owed_results[$];
   expiry_result_type owed_front;

   // our own copy of the timer queue
   logic [63:0] tick_now;
   logic [63:0] slot_deadline [TIMER_SLOTS];
   bit          slot_armed [TIMER_SLOTS];
   logic [3:0]  queue_order [TIMER_SLOTS];
   int          queue_depth;

   int  mismatch_count;
   int  cycle_count;
   bit  sender_idles;

   sorted_timer_expiry_queue_core #(
      .NUM_TIMERS(TIMER_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_timer_id(req_timer_id),
      .req_delay(req_delay),
      .rsp_strobe(rsp_strobe),
      .rsp_kind(rsp_kind),
      .rsp_fired_id(rsp_fired_id),
      .rsp_last(rsp_last),
      .rsp_due_now(rsp_due_now),
      .rsp_queued_count(rsp_queued_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, in case the block stops answering
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_timer_expiry_queue_core_test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // head of the queue is due once its deadline has been reached
   function automatic bit head_is_due();
      if (queue_depth == 0) return 1'b0;
      return slot_deadline[queue_order[0]] <= tick_now;
   endfunction

   // the due flag and the count reflect the queue after this result's change
   function automatic void owe_result(input logic [1:0] kind, input logic [3:0] id,
                                      input logic last);
      expiry_result_type r;
      r.kind  = kind;
      r.id    = id;
      r.last  = last;
      r.due   = head_is_due();
      r.count = queue_depth[4:0];
      owed_results.push_back(r);
   endfunction

   function automatic void drop_queue_entry(input int pos);
      for (int k = pos; k < queue_depth - 1; k++) queue_order[k] = queue_order[k + 1];
      queue_depth--;
   endfunction

   // works out every result that one accepted request should cause
   function automatic void predict_request(input logic [1:0] kind_req,
                                           input logic [3:0] id,
                                           input logic [31:0] dly);
      logic [63:0] deadline;
      logic [3:0]  fid;
      int          pos;
      int          fired;
      case (kind_req)
         REQ_ADD: begin
            if (slot_armed[id] || queue_depth >= TIMER_SLOTS) begin
               owe_result(KIND_REFUSED, id, 1'b1);
            end else begin
               deadline = tick_now + {32'd0, dly};
               pos = 0;
               // goes ahead of the first entry due at the same time or later
               while (pos < queue_depth && slot_deadline[queue_order[pos]] < deadline) pos++;
               for (int k = queue_depth; k > pos; k--) queue_order[k] = queue_order[k - 1];
               queue_order[pos] = id;
               queue_depth++;
               slot_deadline[id] = deadline;
               slot_armed[id] = 1'b1;
               owe_result(KIND_DONE, id, 1'b1);
            end
         end
         REQ_DELETE: begin
            if (slot_armed[id]) begin
               for (int k = 0; k < queue_depth; k++) begin
                  if (queue_order[k] == id) begin
                     drop_queue_entry(k);
                     break;
                  end
               end
               slot_armed[id] = 1'b0;
            end
            owe_result(KIND_DONE, id, 1'b1);
         end
         REQ_TICK: begin
            tick_now = tick_now + 64'd1;
            fired = 0;
            while (fired < TIMER_SLOTS && head_is_due()) begin
               fid = queue_order[0];
               drop_queue_entry(0);
               slot_armed[fid] = 1'b0;
               owe_result(KIND_FIRED, fid, !head_is_due());
               fired++;
            end
            if (fired == 0) owe_result(KIND_DONE, 4'd0, 1'b1);
            else owed_results[$].last = 1'b1;
         end
         default: begin
            owe_result(KIND_REFUSED, id, 1'b1);
         end
      endcase
   endfunction

   // one request: optional idle gap, then hold start until busy is low at an edge
   task automatic send_request(input logic [1:0] kind_req, input logic [3:0] id,
                               input logic [31:0] dly);
      if (sender_idles && $urandom_range(99) < 16) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start        <= 1'b1;
      req_type     <= kind_req;
      req_timer_id <= id;
      req_delay    <= dly;
      @(posedge clock);
      while (busy) @(posedge clock);
      // taken at this edge, so the expected results are owed from here on
      predict_request(kind_req, id, dly);
   endtask

   // every strobed result is matched against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d id %0d",
                                      rsp_kind, rsp_fired_id));
         end else begin
            owed_front = owed_results.pop_front();
            if (rsp_kind !== owed_front.kind)
               report_mismatch($sformatf("rsp_kind %0d, want %0d", rsp_kind, owed_front.kind));
            if (rsp_fired_id !== owed_front.id)
               report_mismatch($sformatf("rsp_fired_id %0d, want %0d",
                                         rsp_fired_id, owed_front.id));
            if (rsp_last !== owed_front.last)
               report_mismatch($sformatf("rsp_last %0d, want %0d", rsp_last, owed_front.last));
            if (rsp_due_now !== owed_front.due)
               report_mismatch($sformatf("rsp_due_now %0d, want %0d",
                                         rsp_due_now, owed_front.due));
            if (rsp_queued_count !== owed_front.count)
               report_mismatch($sformatf("rsp_queued_count %0d, want %0d",
                                         rsp_queued_count, owed_front.count));
         end
      end
   end

   // a tick on an empty queue answers with a single done result
   task automatic test_idle_tick();
      send_request(REQ_TICK, 4'd0, 32'd0);
   endtask

   // every slot armed for the same tick: a full queue refuses an add, then
   // one tick fires all sixteen back to back, newest first
   task automatic test_full_burst();
      for (int k = 0; k < TIMER_SLOTS; k++) send_request(REQ_ADD, k[3:0], 32'd1);
      send_request(REQ_ADD, 4'd5, 32'd3);
      send_request(REQ_TICK, 4'd0, 32'd0);
   endtask

   // refusals, deletes and the widest delays
   task automatic test_refusals_and_delete();
      send_request(REQ_ADD, 4'd0, 32'd0);           // due the moment it is added
      send_request(REQ_ADD, 4'd0, 32'd7);           // already active, refused
      send_request(REQ_DELETE, 4'd7, 32'd0);        // inactive, nothing to do
      send_request(REQ_UNKNOWN, 4'd9, 32'hA5A5_5A5A);
      send_request(REQ_ADD, 4'd15, 32'hFFFF_FFFF);  // furthest possible expiry
      send_request(REQ_DELETE, 4'd15, 32'd0);
      send_request(REQ_TICK, 4'd0, 32'd0);
   endtask

   // mostly short delays so timers keep firing, a few far ones to clog slots
   function automatic logic [31:0] pick_delay();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(6);
      if (roll < 85) return $urandom_range(40);
      if (roll < 95) return $urandom();
      return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
   endfunction

   task automatic test_random_traffic(input int request_total);
      int          roll;
      logic [1:0]  kind_req;
      for (int n = 0; n < request_total; n++) begin
         // a long run with the sender never pausing
         sender_idles = !(n >= 90 && n < 160);
         roll = $urandom_range(99);
         if (roll < 38) kind_req = REQ_ADD;
         else if (roll < 58) kind_req = REQ_DELETE;
         else if (roll < 95) kind_req = REQ_TICK;
         else kind_req = REQ_UNKNOWN;
         send_request(kind_req, 4'($urandom_range(15)), pick_delay());
      end
      sender_idles = 1'b1;
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      sender_idles   = 1'b1;
      tick_now       = 64'd0;
      queue_depth    = 0;
      for (int k = 0; k < TIMER_SLOTS; k++) slot_armed[k] = 1'b0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_type     <= REQ_TICK;
      req_timer_id <= 4'd0;
      req_delay    <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_tick();
      test_full_burst();
      test_refusals_and_delete();
      test_random_traffic(234);

      // stimulus done, let every owed result come out
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_timer_expiry_queue_core_test passed");
      end else begin
         $display("sorted_timer_expiry_queue_core_test failed");
      end
      $finish;
   end

endmodule
